/* hdl/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and types for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // pool geometry
  localparam int MaxBlocks = 1024;
  localparam int RingDepth = MaxBlocks + 1;
  localparam int RingAw    = $clog2(RingDepth);
  localparam int IdxW      = $clog2(MaxBlocks);
  localparam int CntW      = $clog2(MaxBlocks + 1);

  // field widths
  localparam int AddrW   = 32;
  localparam int SizeW   = 32;
  localparam int BsizeW  = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 32;
  localparam int ProdW   = BsizeW + IdxW;

  // divider
  localparam int DivSteps = AddrW;
  localparam int DivCntW  = $clog2(DivSteps);

  // reset values
  localparam logic [BsizeW-1:0] BsizeRst = BsizeW'(512);
  localparam logic [AddrW-1:0]  BaseRst  = '0;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBlockSize  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockCount = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPoolBase   = 2'd2;

  // request types
  localparam logic [1:0] ReqAlloc = 2'd0;
  localparam logic [1:0] ReqFree  = 2'd1;
  localparam logic [1:0] ReqQuery = 2'd2;

  // status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StNoBlock   = 2'd1;
  localparam logic [1:0] StNotInPool = 2'd2;
  localparam logic [1:0] StMisalign  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARD,
    S_AMUL,
    S_AADD,
    S_DIV,
    S_CHK
  } fbpa_state_t;

endpackage

/* hdl/fixed_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a ring of free block indices held in one RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and each request
// produces exactly one result, shown for one cycle with out_valid; the
// receiver cannot stall, so results must be captured when they appear.
// Rejected requests (allocate too large or ring empty, address below the
// pool, zero block size) answer the cycle after the request, as does an
// unknown type, which answers ok. An allocate that succeeds takes one RAM
// read of the free ring, one multiply of block size by index and one add of
// the pool base. For free and query, a one-bit-per-cycle divider runs 32
// steps over the offset from the pool base, then the index and
// remainder are checked and a free pushes its index into the ring. The ring
// needs no clearing pass after reset or a block_count write: unwritten
// entries read as their own position, tracked by a fill mark. Configuration
// writes are taken only while busy is low and start is low, so a request
// and a write offered in the same cycle take the request first.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [fbpa_pkg::SizeW-1:0]     in_req_size,
  input  logic [fbpa_pkg::AddrW-1:0]     in_address,
  // result channel
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [fbpa_pkg::AddrW-1:0]     out_block_address,
  output logic [fbpa_pkg::BsizeW-1:0]    out_size_reply,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fbpa_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [fbpa_pkg::CfgDatW-1:0]   cfg_wdata
);

  fbpa_pkg::fbpa_state_t state_r, state_nxt;

  // configuration
  logic [fbpa_pkg::BsizeW-1:0] bsize_r, bsize_nxt;
  logic [fbpa_pkg::CntW-1:0]   bcount_r, bcount_nxt;
  logic [fbpa_pkg::AddrW-1:0]  base_r, base_nxt;

  // ring pointers and fill mark
  logic [fbpa_pkg::RingAw-1:0] take_r, take_nxt;
  logic [fbpa_pkg::RingAw-1:0] put_r, put_nxt;
  logic [fbpa_pkg::CntW-1:0]   mark_r, mark_nxt;

  // request and datapath
  logic [1:0]                   type_r, type_nxt;
  logic [fbpa_pkg::AddrW-1:0]   quo_r, quo_nxt;
  logic [fbpa_pkg::BsizeW-1:0]  rem_r, rem_nxt;
  logic [fbpa_pkg::DivCntW-1:0] dcnt_r, dcnt_nxt;
  logic [fbpa_pkg::ProdW-1:0]   prod_r, prod_nxt;

  // result registers
  logic                         out_valid_r, out_valid_nxt;
  logic [1:0]                   out_status_r, out_status_nxt;
  logic [fbpa_pkg::AddrW-1:0]   out_addr_r, out_addr_nxt;
  logic [fbpa_pkg::BsizeW-1:0]  out_size_r, out_size_nxt;

  // ring memory
  logic [fbpa_pkg::IdxW-1:0]    ring_mem [fbpa_pkg::RingDepth];
  logic [fbpa_pkg::IdxW-1:0]    rd_data_r;
  logic                         mem_we;
  logic [fbpa_pkg::IdxW-1:0]    mem_wd;

  // helpers
  logic [fbpa_pkg::BsizeW:0]    trial;
  logic [fbpa_pkg::BsizeW:0]    trial_sub;
  logic [fbpa_pkg::IdxW-1:0]    blk_idx;
  logic [fbpa_pkg::RingAw-1:0]  take_adv;
  logic [fbpa_pkg::RingAw-1:0]  put_adv;
  logic [fbpa_pkg::CntW-1:0]    put_end;
  logic [fbpa_pkg::CntW-1:0]    cnt_sat;
  logic                         cfg_fire;

  assign busy              = (state_r != fbpa_pkg::S_IDLE);
  assign cfg_ready         = (state_r == fbpa_pkg::S_IDLE) & !start;
  assign cfg_fire          = cfg_valid & cfg_ready;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_size_reply    = out_size_r;

  // pointer stepping: both wrap from block_count back to zero
  assign take_adv = (take_r == fbpa_pkg::RingAw'(bcount_r)) ? '0 : take_r + 1'b1;
  assign put_adv  = (put_r == fbpa_pkg::RingAw'(bcount_r)) ? '0 : put_r + 1'b1;
  assign put_end  = fbpa_pkg::CntW'(put_r) + 1'b1;

  // entries never written since refill hold their own position
  assign blk_idx = ((fbpa_pkg::CntW'(take_r) < bcount_r) &&
                    (fbpa_pkg::CntW'(take_r) >= mark_r))
                   ? take_r[fbpa_pkg::IdxW-1:0] : rd_data_r;

  // restoring divide step
  assign trial     = {rem_r, quo_r[fbpa_pkg::AddrW-1]};
  assign trial_sub = trial - {1'b0, bsize_r};

  assign cnt_sat = (cfg_wdata[fbpa_pkg::CntW-1:0] > fbpa_pkg::CntW'(fbpa_pkg::MaxBlocks))
                   ? fbpa_pkg::CntW'(fbpa_pkg::MaxBlocks)
                   : cfg_wdata[fbpa_pkg::CntW-1:0];

  always_comb begin
    state_nxt      = state_r;
    bsize_nxt      = bsize_r;
    bcount_nxt     = bcount_r;
    base_nxt       = base_r;
    take_nxt       = take_r;
    put_nxt        = put_r;
    mark_nxt       = mark_r;
    type_nxt       = type_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dcnt_nxt       = dcnt_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_size_nxt   = out_size_r;
    mem_we         = 1'b0;
    mem_wd         = quo_r[fbpa_pkg::IdxW-1:0];

    case (state_r)
      fbpa_pkg::S_IDLE: begin
        if (start) begin
          type_nxt = in_req_type;
          case (in_req_type)
            fbpa_pkg::ReqAlloc: begin
              if (bsize_r == '0 ||
                  in_req_size > fbpa_pkg::SizeW'(bsize_r) ||
                  take_r == put_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = fbpa_pkg::StNoBlock;
                out_addr_nxt   = '0;
                out_size_nxt   = '0;
              end else begin
                state_nxt = fbpa_pkg::S_ARD;
              end
            end
            fbpa_pkg::ReqFree, fbpa_pkg::ReqQuery: begin
              if (bsize_r == '0 || in_address < base_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = fbpa_pkg::StNotInPool;
                out_addr_nxt   = '0;
                out_size_nxt   = '0;
              end else begin
                quo_nxt   = in_address - base_r;
                rem_nxt   = '0;
                dcnt_nxt  = '0;
                state_nxt = fbpa_pkg::S_DIV;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = fbpa_pkg::StOk;
              out_addr_nxt   = '0;
              out_size_nxt   = '0;
            end
          endcase
        end
        if (cfg_fire) begin
          case (cfg_index)
            fbpa_pkg::CfgBlockSize: bsize_nxt = cfg_wdata[fbpa_pkg::BsizeW-1:0];
            fbpa_pkg::CfgBlockCount: begin
              bcount_nxt = cnt_sat;
              take_nxt   = '0;
              put_nxt    = fbpa_pkg::RingAw'(cnt_sat);
              mark_nxt   = '0;
            end
            fbpa_pkg::CfgPoolBase: base_nxt = cfg_wdata[fbpa_pkg::AddrW-1:0];
            default: ;
          endcase
        end
      end

      // ring read at take pointer in flight
      fbpa_pkg::S_ARD: begin
        state_nxt = fbpa_pkg::S_AMUL;
      end

      fbpa_pkg::S_AMUL: begin
        prod_nxt  = bsize_r * blk_idx;
        take_nxt  = take_adv;
        state_nxt = fbpa_pkg::S_AADD;
      end

      fbpa_pkg::S_AADD: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = fbpa_pkg::StOk;
        out_addr_nxt   = base_r + fbpa_pkg::AddrW'(prod_r);
        out_size_nxt   = '0;
        state_nxt      = fbpa_pkg::S_IDLE;
      end

      fbpa_pkg::S_DIV: begin
        if (!trial_sub[fbpa_pkg::BsizeW]) begin
          rem_nxt = trial_sub[fbpa_pkg::BsizeW-1:0];
          quo_nxt = {quo_r[fbpa_pkg::AddrW-2:0], 1'b1};
        end else begin
          rem_nxt = trial[fbpa_pkg::BsizeW-1:0];
          quo_nxt = {quo_r[fbpa_pkg::AddrW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == fbpa_pkg::DivCntW'(fbpa_pkg::DivSteps - 1)) begin
          state_nxt = fbpa_pkg::S_CHK;
        end
      end

      fbpa_pkg::S_CHK: begin
        out_valid_nxt = 1'b1;
        out_addr_nxt  = '0;
        out_size_nxt  = '0;
        state_nxt     = fbpa_pkg::S_IDLE;
        if (quo_r >= fbpa_pkg::AddrW'(bcount_r)) begin
          out_status_nxt = fbpa_pkg::StNotInPool;
        end else if (rem_r != '0) begin
          out_status_nxt = fbpa_pkg::StMisalign;
        end else begin
          out_status_nxt = fbpa_pkg::StOk;
          if (type_r == fbpa_pkg::ReqQuery) begin
            out_size_nxt = bsize_r;
          end else if (put_adv != take_r) begin
            // full ring drops the push silently
            mem_we  = 1'b1;
            put_nxt = put_adv;
            if (fbpa_pkg::CntW'(put_r) < bcount_r && put_end > mark_r) begin
              mark_nxt = put_end;
            end
          end
        end
      end

      default: begin
        state_nxt = fbpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbpa_pkg::S_IDLE;
      bsize_r     <= fbpa_pkg::BsizeRst;
      bcount_r    <= fbpa_pkg::CntW'(fbpa_pkg::MaxBlocks);
      base_r      <= fbpa_pkg::BaseRst;
      take_r      <= '0;
      put_r       <= fbpa_pkg::RingAw'(fbpa_pkg::MaxBlocks);
      mark_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bsize_r     <= bsize_nxt;
      bcount_r    <= bcount_nxt;
      base_r      <= base_nxt;
      take_r      <= take_nxt;
      put_r       <= put_nxt;
      mark_r      <= mark_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r       <= type_nxt;
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    dcnt_r       <= dcnt_nxt;
    prod_r       <= prod_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_size_r   <= out_size_nxt;
  end

  // free index ring
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[put_r] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= ring_mem[take_r];
  end

endmodule
